### rtl/ifcs_pkg.sv
package ifcs_pkg;

   // Sequencer phases; also used as the continuation code after the enable pair
   typedef enum logic [4:0] {
      PH_IDLE, PH_EN, PH_EXT, PH_TSIG, PH_SSIG, PH_ERASE, PH_PAGE,
      PH_RLO, PH_RHI, PH_LLO, PH_LHI, PH_WPAGE, PH_VLO, PH_VHI,
      PH_FREAD, PH_FWRITE, PH_FVERIFY, PH_BLOCK, PH_EREAD, PH_EWRITE, PH_EVERIFY
   } phase_type;

   localparam logic [7:0] CMD_PROG_EN    = 8'hAC;
   localparam logic [7:0] CMD_PROG_EN2   = 8'h53;
   localparam logic [7:0] CMD_ERASE2     = 8'h80;
   localparam logic [7:0] CMD_LOAD_EXT   = 8'h4D;
   localparam logic [7:0] CMD_READ_SIG   = 8'h30;
   localparam logic [7:0] CMD_READ_LO    = 8'h20;
   localparam logic [7:0] CMD_READ_HI    = 8'h28;
   localparam logic [7:0] CMD_LOAD_LO    = 8'h40;
   localparam logic [7:0] CMD_LOAD_HI    = 8'h48;
   localparam logic [7:0] CMD_WRITE_PAGE = 8'h4C;
   localparam logic [7:0] CMD_EE_READ    = 8'hA0;
   localparam logic [7:0] CMD_EE_WRITE   = 8'hC0;

   localparam logic [3:0] WAIT_NONE  = 4'd0;
   localparam logic [3:0] WAIT_EE    = 4'd4;
   localparam logic [3:0] WAIT_PAGE  = 4'd5;
   localparam logic [3:0] WAIT_ERASE = 4'd10;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   localparam logic [2:0] CSR_SMALL_SIG   = 3'd0;
   localparam logic [2:0] CSR_SMALL_PAGES = 3'd1;
   localparam logic [2:0] CSR_LARGE_SIG   = 3'd2;
   localparam logic [2:0] CSR_LARGE_PAGES = 3'd3;
   localparam logic [2:0] CSR_PAGE_WORDS  = 3'd4;
   localparam logic [2:0] CSR_EE_BYTES    = 3'd5;

   typedef struct packed {
      logic [23:0] small_sig;
      logic [7:0]  small_pages;
      logic [23:0] large_sig;
      logic [7:0]  large_pages;
      logic [5:0]  page_words;
      logic [8:0]  eeprom_bytes;
   } cfg_type;

   typedef struct packed {
      logic       port;
      logic       strobe_reset;
      logic [7:0] tx_first;
      logic [7:0] tx_second;
      logic [7:0] tx_third;
      logic [7:0] tx_fourth;
      logic [3:0] post_wait_ms;
      logic [1:0] status;
   } txn_type;

   function automatic logic port_of(input phase_type ph);
      case (ph)
         PH_TSIG, PH_ERASE, PH_LLO, PH_LHI, PH_WPAGE, PH_VLO, PH_VHI,
         PH_FWRITE, PH_FVERIFY, PH_EWRITE, PH_EVERIFY: port_of = 1'b1;
         default: port_of = 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] fuse_rd_a(input logic [1:0] j);
      case (j)
         2'd1: fuse_rd_a = 8'h58;
         default: fuse_rd_a = 8'h50;
      endcase
   endfunction

   function automatic logic [7:0] fuse_rd_b(input logic [1:0] j);
      case (j)
         2'd0: fuse_rd_b = 8'h00;
         default: fuse_rd_b = 8'h08;
      endcase
   endfunction

   function automatic logic [7:0] fuse_wr_b(input logic [1:0] j);
      case (j)
         2'd0: fuse_wr_b = 8'hA0;
         2'd1: fuse_wr_b = 8'hA8;
         default: fuse_wr_b = 8'hA4;
      endcase
   endfunction

   function automatic txn_type mk_txn(input logic p, input logic s, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] c,
                                      input logic [7:0] d, input logic [3:0] w,
                                      input logic [1:0] st);
      txn_type t;
      t.port = p;
      t.strobe_reset = s;
      t.tx_first = a;
      t.tx_second = b;
      t.tx_third = c;
      t.tx_fourth = d;
      t.post_wait_ms = w;
      t.status = st;
      return t;
   endfunction

endpackage

### rtl/ifcs_channels_if.sv
interface ifcs_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;
   modport source (output valid, func, rx_byte, input ready);
   modport sink (input valid, func, rx_byte, output ready);
endinterface

interface ifcs_rsp_if;
   logic       valid;
   logic       ready;
   logic       port;
   logic       strobe_reset;
   logic [7:0] tx_first;
   logic [7:0] tx_second;
   logic [7:0] tx_third;
   logic [7:0] tx_fourth;
   logic [3:0] post_wait_ms;
   logic [1:0] status;
   modport source (output valid, port, strobe_reset, tx_first, tx_second, tx_third,
                   tx_fourth, post_wait_ms, status, input ready);
   modport sink (input valid, port, strobe_reset, tx_first, tx_second, tx_third,
                 tx_fourth, post_wait_ms, status, output ready);
endinterface

### rtl/ifcs_buffer_mem.sv
module ifcs_buffer_mem #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [7:0]               rd_a_data,
   output logic [7:0]               rd_b_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data
);
   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;
endmodule

### rtl/ifcs_seq.sv
module ifcs_seq import ifcs_pkg::*; #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       commit,
   input  logic       func,
   input  logic [7:0] rx,
   output logic       emit,
   output txn_type    txn
);
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int SW = ($clog2(BUFFER_BYTES + 1) > 6) ? $clog2(BUFFER_BYTES + 1) : 6;
   localparam int BW = $clog2(512 / BUFFER_BYTES + 1);
   localparam int EW = BW + 10;

   phase_type        phase_ff, phase_in, cont_ff, cont_in, start_ph;
   logic [SW-1:0]    step_ff, step_in, step_inc;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [7:0]       page_ff, page_in;
   logic [BW-1:0]    block_ff, block_in;
   logic [23:0]      sig_ff, sig_in;
   logic [7:0]       tp_ff, tp_in, ap_ff, ap_in, low_ff, low_in, pages;
   logic [7:0]       fuse_ff [3];
   logic [7:0]       fuse_in [3];
   logic             go_start, wr_en;
   logic [AW-1:0]    wr_addr, rd_a_addr, rd_b_addr;
   logic [7:0]       rd_a_data, rd_b_data;
   logic [15:0]      wa, pb;
   logic [EW-1:0]    blk_lim;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [1:0] k);
      logic [AW:0] t;
      t = (AW+1)'(p) + (AW+1)'(k);
      if (t >= (AW+1)'(BUFFER_BYTES)) t = t - (AW+1)'(BUFFER_BYTES);
      return t[AW-1:0];
   endfunction

   function automatic logic [15:0] word_addr(input logic [7:0] pg, input logic [5:0] pw,
                                             input logic [SW-1:0] s);
      return 16'(pg) * 16'(pw) + 16'(s);
   endfunction

   function automatic logic [7:0] ee_addr(input logic [BW-1:0] b, input logic [SW-1:0] s);
      logic [EW-1:0] t;
      t = EW'(b) * EW'(BUFFER_BYTES) + EW'(s);
      return t[7:0];
   endfunction

   // Read addresses follow the current state, so the registered read data is ready for the step
   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = '0;
      case (phase_ff)
         PH_LLO:     rd_a_addr = wrap_add(ptr_ff, 2'd1);
         PH_LHI:     rd_a_addr = wrap_add(ptr_ff, 2'd2);
         PH_VHI: begin
            rd_a_addr = ptr_ff;
            rd_b_addr = wrap_add(ptr_ff, 2'd1);
         end
         PH_EWRITE:  rd_a_addr = AW'(step_ff + 1'b1);
         PH_EVERIFY: rd_a_addr = step_ff[AW-1:0];
         default:    rd_a_addr = '0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      cont_in  = cont_ff;
      step_in  = step_ff;
      page_in  = page_ff;
      block_in = block_ff;
      sig_in   = sig_ff;
      tp_in    = tp_ff;
      ap_in    = ap_ff;
      low_in   = low_ff;
      fuse_in  = fuse_ff;
      ptr_in   = ptr_ff;
      emit     = 1'b1;
      txn      = '0;
      go_start = 1'b0;
      start_ph = PH_IDLE;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      pages    = '0;
      step_inc = step_ff + 1'b1;
      pb       = word_addr(page_ff, cfg.page_words, '0);
      wa       = word_addr(page_ff, cfg.page_words, step_ff);
      blk_lim  = '0;
      if (!func) begin
         page_in  = '0;
         block_in = '0;
         tp_in    = '0;
         ap_in    = '0;
         low_in   = '0;
         sig_in   = '0;
         phase_in = PH_EN;
         cont_in  = PH_TSIG;
         txn = mk_txn(port_of(PH_TSIG), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00, 8'h00,
                      WAIT_NONE, ST_OK);
      end else begin
         case (phase_ff)
            PH_EN: begin
               phase_in = PH_EXT;
               txn = mk_txn(port_of(cont_ff), 1'b0, CMD_LOAD_EXT, 8'h00, 8'h00, 8'h00,
                            WAIT_NONE, ST_OK);
            end
            PH_EXT: begin
               go_start = 1'b1;
               start_ph = cont_ff;
            end
            PH_TSIG, PH_SSIG: begin
               if (step_ff < SW'(3)) begin
                  sig_in = sig_ff | ({16'h0000, rx} << {step_ff[1:0], 3'b000});
               end
               step_in = step_inc;
               if (step_inc < SW'(4)) begin
                  txn = mk_txn(port_of(phase_ff), 1'b0, CMD_READ_SIG, 8'h00, 8'(step_inc),
                               8'h00, WAIT_NONE, ST_OK);
               end else if (sig_in == cfg.large_sig || sig_in == cfg.small_sig) begin
                  pages = (sig_in == cfg.large_sig) ? cfg.large_pages : cfg.small_pages;
                  phase_in = PH_EN;
                  if (phase_ff == PH_TSIG) begin
                     tp_in   = pages;
                     cont_in = PH_SSIG;
                  end else begin
                     ap_in   = (tp_ff < pages) ? tp_ff : pages;
                     cont_in = PH_ERASE;
                  end
                  txn = mk_txn(port_of(cont_in), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00,
                               8'h00, WAIT_NONE, ST_OK);
               end else begin
                  phase_in = PH_IDLE;
                  step_in  = '0;
                  txn = mk_txn(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, WAIT_NONE, ST_FAIL);
               end
            end
            PH_ERASE: begin
               phase_in = PH_EN;
               cont_in  = PH_PAGE;
               txn = mk_txn(port_of(PH_PAGE), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00, 8'h00,
                            WAIT_NONE, ST_OK);
            end
            PH_RLO: begin
               wr_en    = 1'b1;
               wr_addr  = ptr_ff;
               phase_in = PH_RHI;
               txn = mk_txn(port_of(PH_RHI), 1'b0, CMD_READ_HI, wa[15:8], wa[7:0], 8'h00,
                            WAIT_NONE, ST_OK);
            end
            PH_RHI: begin
               wr_en   = 1'b1;
               wr_addr = wrap_add(ptr_ff, 2'd1);
               step_in = step_inc;
               wa      = word_addr(page_ff, cfg.page_words, step_inc);
               if (step_inc < SW'(cfg.page_words)) begin
                  phase_in = PH_RLO;
                  txn = mk_txn(port_of(PH_RLO), 1'b0, CMD_READ_LO, wa[15:8], wa[7:0], 8'h00,
                               WAIT_NONE, ST_OK);
               end else begin
                  phase_in = PH_EN;
                  cont_in  = PH_LLO;
                  txn = mk_txn(port_of(PH_LLO), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00,
                               8'h00, WAIT_NONE, ST_OK);
               end
            end
            PH_LLO: begin
               phase_in = PH_LHI;
               txn = mk_txn(port_of(PH_LHI), 1'b0, CMD_LOAD_HI, 8'h00, wa[7:0], rd_a_data,
                            WAIT_NONE, ST_OK);
            end
            PH_LHI: begin
               step_in = step_inc;
               wa      = word_addr(page_ff, cfg.page_words, step_inc);
               if (step_inc < SW'(cfg.page_words)) begin
                  phase_in = PH_LLO;
                  txn = mk_txn(port_of(PH_LLO), 1'b0, CMD_LOAD_LO, 8'h00, wa[7:0], rd_a_data,
                               WAIT_NONE, ST_OK);
               end else begin
                  phase_in = PH_WPAGE;
                  txn = mk_txn(port_of(PH_WPAGE), 1'b0, CMD_WRITE_PAGE, pb[15:8], pb[7:0],
                               8'h00, WAIT_PAGE, ST_OK);
               end
            end
            PH_WPAGE: begin
               step_in = '0;
               if (cfg.page_words == '0) begin
                  page_in  = page_ff + 8'd1;
                  go_start = 1'b1;
                  start_ph = PH_PAGE;
               end else begin
                  phase_in = PH_VLO;
                  txn = mk_txn(port_of(PH_VLO), 1'b0, CMD_READ_LO, pb[15:8], pb[7:0], 8'h00,
                               WAIT_NONE, ST_OK);
               end
            end
            PH_VLO: begin
               low_in   = rx;
               phase_in = PH_VHI;
               txn = mk_txn(port_of(PH_VHI), 1'b0, CMD_READ_HI, wa[15:8], wa[7:0], 8'h00,
                            WAIT_NONE, ST_OK);
            end
            PH_VHI: begin
               if (low_ff != rd_a_data || rx != rd_b_data) begin
                  phase_in = PH_IDLE;
                  step_in  = '0;
                  txn = mk_txn(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, WAIT_NONE, ST_FAIL);
               end else begin
                  step_in = step_inc;
                  wa      = word_addr(page_ff, cfg.page_words, step_inc);
                  if (step_inc < SW'(cfg.page_words)) begin
                     phase_in = PH_VLO;
                     txn = mk_txn(port_of(PH_VLO), 1'b0, CMD_READ_LO, wa[15:8], wa[7:0],
                                  8'h00, WAIT_NONE, ST_OK);
                  end else begin
                     page_in  = page_ff + 8'd1;
                     go_start = 1'b1;
                     start_ph = PH_PAGE;
                  end
               end
            end
            PH_FREAD: begin
               fuse_in[step_ff[1:0]] = rx;
               step_in = step_inc;
               if (step_inc < SW'(3)) begin
                  txn = mk_txn(port_of(PH_FREAD), 1'b0, fuse_rd_a(step_inc[1:0]),
                               fuse_rd_b(step_inc[1:0]), 8'h00, 8'h00, WAIT_NONE, ST_OK);
               end else begin
                  phase_in = PH_EN;
                  cont_in  = PH_FWRITE;
                  txn = mk_txn(port_of(PH_FWRITE), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00,
                               8'h00, WAIT_NONE, ST_OK);
               end
            end
            PH_FWRITE: begin
               step_in = step_inc;
               if (step_inc < SW'(3)) begin
                  txn = mk_txn(port_of(PH_FWRITE), 1'b0, CMD_PROG_EN,
                               fuse_wr_b(step_inc[1:0]), 8'h00, fuse_ff[step_inc[1:0]],
                               WAIT_PAGE, ST_OK);
               end else begin
                  step_in  = '0;
                  phase_in = PH_FVERIFY;
                  txn = mk_txn(port_of(PH_FVERIFY), 1'b0, fuse_rd_a(2'd0), fuse_rd_b(2'd0),
                               8'h00, 8'h00, WAIT_NONE, ST_OK);
               end
            end
            PH_FVERIFY: begin
               if (rx != fuse_ff[step_ff[1:0]]) begin
                  phase_in = PH_IDLE;
                  step_in  = '0;
                  txn = mk_txn(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, WAIT_NONE, ST_FAIL);
               end else begin
                  step_in = step_inc;
                  if (step_inc < SW'(3)) begin
                     txn = mk_txn(port_of(PH_FVERIFY), 1'b0, fuse_rd_a(step_inc[1:0]),
                                  fuse_rd_b(step_inc[1:0]), 8'h00, 8'h00, WAIT_NONE, ST_OK);
                  end else begin
                     block_in = '0;
                     go_start = 1'b1;
                     start_ph = PH_BLOCK;
                  end
               end
            end
            PH_EREAD: begin
               wr_en   = 1'b1;
               wr_addr = step_ff[AW-1:0];
               step_in = step_inc;
               if (step_inc < SW'(BUFFER_BYTES)) begin
                  txn = mk_txn(port_of(PH_EREAD), 1'b0, CMD_EE_READ, 8'h00,
                               ee_addr(block_ff, step_inc), 8'h00, WAIT_NONE, ST_OK);
               end else begin
                  phase_in = PH_EN;
                  cont_in  = PH_EWRITE;
                  txn = mk_txn(port_of(PH_EWRITE), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00,
                               8'h00, WAIT_NONE, ST_OK);
               end
            end
            PH_EWRITE: begin
               step_in = step_inc;
               if (step_inc < SW'(BUFFER_BYTES)) begin
                  txn = mk_txn(port_of(PH_EWRITE), 1'b0, CMD_EE_WRITE, 8'h00,
                               ee_addr(block_ff, step_inc), rd_a_data, WAIT_EE, ST_OK);
               end else begin
                  step_in  = '0;
                  phase_in = PH_EVERIFY;
                  txn = mk_txn(port_of(PH_EVERIFY), 1'b0, CMD_EE_READ, 8'h00,
                               ee_addr(block_ff, '0), 8'h00, WAIT_NONE, ST_OK);
               end
            end
            PH_EVERIFY: begin
               if (rx != rd_a_data) begin
                  phase_in = PH_IDLE;
                  step_in  = '0;
                  txn = mk_txn(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, WAIT_NONE, ST_FAIL);
               end else begin
                  step_in = step_inc;
                  if (step_inc < SW'(BUFFER_BYTES)) begin
                     txn = mk_txn(port_of(PH_EVERIFY), 1'b0, CMD_EE_READ, 8'h00,
                                  ee_addr(block_ff, step_inc), 8'h00, WAIT_NONE, ST_OK);
                  end else begin
                     block_in = block_ff + 1'b1;
                     go_start = 1'b1;
                     start_ph = PH_BLOCK;
                  end
               end
            end
            default: begin
               // idle: drop the response
               emit     = 1'b0;
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (go_start) begin
         wa = word_addr(page_ff, cfg.page_words, '0);
         blk_lim = (EW'(block_in) + EW'(1)) * EW'(BUFFER_BYTES);
         case (start_ph)
            PH_TSIG, PH_SSIG: begin
               sig_in   = '0;
               step_in  = '0;
               phase_in = start_ph;
               txn = mk_txn(port_of(start_ph), 1'b0, CMD_READ_SIG, 8'h00, 8'h00, 8'h00,
                            WAIT_NONE, ST_OK);
            end
            PH_ERASE: begin
               phase_in = PH_ERASE;
               txn = mk_txn(port_of(PH_ERASE), 1'b0, CMD_PROG_EN, CMD_ERASE2, 8'h00, 8'h00,
                            WAIT_ERASE, ST_OK);
            end
            PH_PAGE: begin
               phase_in = PH_EN;
               cont_in  = (page_in < ap_ff) ? PH_RLO : PH_FREAD;
               txn = mk_txn(port_of(cont_in), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00, 8'h00,
                            WAIT_NONE, ST_OK);
            end
            PH_RLO: begin
               step_in = '0;
               if (cfg.page_words == '0) begin
                  phase_in = PH_EN;
                  cont_in  = PH_LLO;
                  txn = mk_txn(port_of(PH_LLO), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00,
                               8'h00, WAIT_NONE, ST_OK);
               end else begin
                  phase_in = PH_RLO;
                  txn = mk_txn(port_of(PH_RLO), 1'b0, CMD_READ_LO, wa[15:8], wa[7:0], 8'h00,
                               WAIT_NONE, ST_OK);
               end
            end
            PH_LLO: begin
               step_in = '0;
               if (cfg.page_words == '0) begin
                  phase_in = PH_WPAGE;
                  txn = mk_txn(port_of(PH_WPAGE), 1'b0, CMD_WRITE_PAGE, pb[15:8], pb[7:0],
                               8'h00, WAIT_PAGE, ST_OK);
               end else begin
                  phase_in = PH_LLO;
                  txn = mk_txn(port_of(PH_LLO), 1'b0, CMD_LOAD_LO, 8'h00, wa[7:0], rd_a_data,
                               WAIT_NONE, ST_OK);
               end
            end
            PH_FREAD: begin
               step_in  = '0;
               phase_in = PH_FREAD;
               txn = mk_txn(port_of(PH_FREAD), 1'b0, fuse_rd_a(2'd0), fuse_rd_b(2'd0), 8'h00,
                            8'h00, WAIT_NONE, ST_OK);
            end
            PH_FWRITE: begin
               step_in  = '0;
               phase_in = PH_FWRITE;
               txn = mk_txn(port_of(PH_FWRITE), 1'b0, CMD_PROG_EN, fuse_wr_b(2'd0), 8'h00,
                            fuse_ff[0], WAIT_PAGE, ST_OK);
            end
            PH_BLOCK: begin
               if (block_in == '0 || blk_lim <= EW'(cfg.eeprom_bytes)) begin
                  phase_in = PH_EN;
                  cont_in  = PH_EREAD;
                  txn = mk_txn(port_of(PH_EREAD), 1'b1, CMD_PROG_EN, CMD_PROG_EN2, 8'h00,
                               8'h00, WAIT_NONE, ST_OK);
               end else begin
                  phase_in = PH_IDLE;
                  step_in  = '0;
                  txn = mk_txn(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, WAIT_NONE, ST_DONE);
               end
            end
            PH_EREAD: begin
               step_in  = '0;
               phase_in = PH_EREAD;
               txn = mk_txn(port_of(PH_EREAD), 1'b0, CMD_EE_READ, 8'h00,
                            ee_addr(block_in, '0), 8'h00, WAIT_NONE, ST_OK);
            end
            PH_EWRITE: begin
               step_in  = '0;
               phase_in = PH_EWRITE;
               txn = mk_txn(port_of(PH_EWRITE), 1'b0, CMD_EE_WRITE, 8'h00,
                            ee_addr(block_in, '0), rd_a_data, WAIT_EE, ST_OK);
            end
            default: begin
               phase_in = PH_IDLE;
               step_in  = '0;
               txn = mk_txn(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, WAIT_NONE, ST_FAIL);
            end
         endcase
      end

      // buffer pointer tracks 2*step modulo the buffer size
      if (step_in == '0) begin
         ptr_in = '0;
      end else if (step_in != step_ff) begin
         ptr_in = wrap_add(ptr_ff, 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cont_ff  <= PH_IDLE;
         step_ff  <= '0;
         ptr_ff   <= '0;
         page_ff  <= '0;
         block_ff <= '0;
         sig_ff   <= '0;
         tp_ff    <= '0;
         ap_ff    <= '0;
         low_ff   <= '0;
      end else if (commit) begin
         phase_ff <= phase_in;
         cont_ff  <= cont_in;
         step_ff  <= step_in;
         ptr_ff   <= ptr_in;
         page_ff  <= page_in;
         block_ff <= block_in;
         sig_ff   <= sig_in;
         tp_ff    <= tp_in;
         ap_ff    <= ap_in;
         low_ff   <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         fuse_ff <= fuse_in;
      end
   end

   ifcs_buffer_mem #(.DEPTH(BUFFER_BYTES)) u_buf (
      .clock     (clock),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (commit && wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (rx)
   );
endmodule

### rtl/isp_flash_copy_sequencer_core.sv
// Channel   Direction  Handshake      Payload
// req_ch    in         valid/ready    func, rx_byte
// rsp_ch    out        valid/ready    port, strobe_reset, tx_first..tx_fourth,
//                                     post_wait_ms, status
// csr_*     in         csr_we         csr_index, csr_wdata
//
// A transaction passes a read stage, which reads the page buffer memory
// (registered read port), then an update stage, which updates the sequencer
// state and loads the response register. The read stage holds one at a time.
// Reset is synchronous; config returns to its defaults, the sequencer to idle.
// A full response register stalls the update stage; req_ch.ready drops until
// the update can retire, so nothing is lost or repeated.
module isp_flash_copy_sequencer_core import ifcs_pkg::*; #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   ifcs_req_if.sink    req_ch,
   ifcs_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   cfg_type cfg_ff;
   logic    s1_v_ff, s2_v_ff, rsp_v_ff;
   logic    func_ff;
   logic [7:0] rx_ff;
   txn_type rsp_ff, txn;
   logic    emit, accept, s2_adv;

   // retire the update stage when the response register is free or draining
   assign s2_adv = s2_v_ff && (!rsp_v_ff || rsp_ch.ready);
   // take a new transaction only when the read stage is empty and the update stage is empty or retiring
   assign req_ch.ready = !s1_v_ff && (!s2_v_ff || s2_adv);
   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.small_sig    <= 24'd496158;
         cfg_ff.small_pages  <= 8'd64;
         cfg_ff.large_sig    <= 24'd824094;
         cfg_ff.large_pages  <= 8'd128;
         cfg_ff.page_words   <= 6'd32;
         cfg_ff.eeprom_bytes <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SMALL_SIG:   cfg_ff.small_sig    <= csr_wdata;
            CSR_SMALL_PAGES: cfg_ff.small_pages  <= csr_wdata[7:0];
            CSR_LARGE_SIG:   cfg_ff.large_sig    <= csr_wdata;
            CSR_LARGE_PAGES: cfg_ff.large_pages  <= csr_wdata[7:0];
            CSR_PAGE_WORDS:  cfg_ff.page_words   <= csr_wdata[5:0];
            CSR_EE_BYTES:    cfg_ff.eeprom_bytes <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // pipeline control: read stage, then update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         if (s1_v_ff) begin
            s2_v_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_v_ff <= 1'b0;
         end
         if (s2_adv && emit) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   // hold the input payload until the update stage retires it; load the response when it emits
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_ch.func;
         rx_ff   <= req_ch.rx_byte;
      end
      if (s2_adv && emit) begin
         rsp_ff <= txn;
      end
   end

   ifcs_seq #(.BUFFER_BYTES(BUFFER_BYTES)) u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .commit (s2_adv),
      .func   (func_ff),
      .rx     (rx_ff),
      .emit   (emit),
      .txn    (txn)
   );

   assign rsp_ch.valid        = rsp_v_ff;
   assign rsp_ch.port         = rsp_ff.port;
   assign rsp_ch.strobe_reset = rsp_ff.strobe_reset;
   assign rsp_ch.tx_first     = rsp_ff.tx_first;
   assign rsp_ch.tx_second    = rsp_ff.tx_second;
   assign rsp_ch.tx_third     = rsp_ff.tx_third;
   assign rsp_ch.tx_fourth    = rsp_ff.tx_fourth;
   assign rsp_ch.post_wait_ms = rsp_ff.post_wait_ms;
   assign rsp_ch.status       = rsp_ff.status;

   a_stages_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(s1_v_ff && s2_v_ff)) else $error("read and update stages both busy");
   a_read_to_update: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |=> s2_v_ff) else $error("read stage did not move to update");
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_v_ff) else $error("accepted transaction lost");
   a_final_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_ff.status != ST_OK) |-> (rsp_ff.tx_first == 8'h00 &&
      rsp_ff.port == 1'b0 && rsp_ff.post_wait_ms == WAIT_NONE))
      else $error("final status carries command bytes");
endmodule
